// File: rtl/sthc_pkg.sv
// ----------------------------------------------------------------------------
// Strip hit clusterer package
// Shared widths, constants and the sequencer state type.
// ----------------------------------------------------------------------------
package sthc_pkg;

  localparam int unsigned PORT_STRIP_W = 12;
  localparam int unsigned LAYER_W      = 5;
  localparam int unsigned TOWER_W      = 4;
  localparam int unsigned TOT_W        = 10;
  localparam int unsigned CFG_W        = 6;
  localparam int unsigned ID_W         = 16;

  localparam logic [CFG_W-1:0] LAYER_COUNT_RESET = 6'd16;
  localparam logic [ID_W-1:0]  ID_MAX            = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INSERT,
    ST_PLACE,
    ST_SCAN0,
    ST_LOAD,
    ST_SCAN,
    ST_FINAL
  } state_e;

endpackage

// File: rtl/sthc_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module sthc_ram #(
  parameter int unsigned Width = 12,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/sthc_cmp.sv
// ----------------------------------------------------------------------------
// Strip compare unit
// Shared magnitude compare: a > b, or a > b + 1 for adjacency tests.
// ----------------------------------------------------------------------------
module sthc_cmp #(
  parameter int unsigned Width = 12
) (
  input  logic [Width-1:0] a_i,
  input  logic [Width-1:0] b_i,
  input  logic             inc_i,
  output logic             gt_o
);

  logic [Width:0] b_ext;

  // one extra bit so that b + 1 cannot wrap
  assign b_ext = {1'b0, b_i} + {{Width{1'b0}}, inc_i};
  assign gt_o  = {1'b0, a_i} > b_ext;

endmodule

// File: rtl/strip_hit_clusterer_unit.sv
// ----------------------------------------------------------------------------
// Strip hit clusterer
// Sorts the hits of one layer into a store by insertion, then walks the
// store and emits one cluster per run of adjacent strips.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | content
//  ---------+-----------+------------------------+------------------------------
//  hit in   | input     | in_valid_i/in_ready_o  | strip, layer, view, tower, tot
//  cluster  | output    | out_valid_o/out_ready_i| id, plane, strips, flags
//  config   | input     | cfg_we_i               | layer_count
//
//  A hit into an empty or a full store is handled in ST_IDLE alone; otherwise
//  ST_INSERT does one RAM read and shift per stored entry above it, then
//  writes the hit, or ST_PLACE does if it belongs below every entry.
//  After the last hit: set-up in ST_SCAN0 and ST_LOAD, then one stored entry
//  per cycle in ST_SCAN, held while a new cluster waits on out_ready_i.
//  in_ready_o is high only while the sequencer is idle; a finished cluster
//  may still wait in the output register meanwhile.
//  Reset clears the counters and flags; store contents need no clearing.
// ----------------------------------------------------------------------------
module strip_hit_clusterer_unit
  import sthc_pkg::*;
#(
  parameter int unsigned MAX_HITS   = 64,
  parameter int unsigned STRIP_BITS = 12
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration
  input  logic                    cfg_we_i,
  input  logic [CFG_W-1:0]        cfg_wdata_i,
  // hit input
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [PORT_STRIP_W-1:0] strip_i,
  input  logic [LAYER_W-1:0]      layer_number_i,
  input  logic                    view_select_i,
  input  logic [TOWER_W-1:0]      tower_number_i,
  input  logic [TOT_W-1:0]        charge_tot_i,
  input  logic                    last_hit_i,
  input  logic                    new_event_i,
  // cluster output
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [ID_W-1:0]         cluster_id_o,
  output logic                    view_out_o,
  output logic [LAYER_W-1:0]      plane_number_o,
  output logic [PORT_STRIP_W-1:0] strip_low_o,
  output logic [PORT_STRIP_W-1:0] strip_high_o,
  output logic [TOT_W-1:0]        tot_out_o,
  output logic [TOWER_W-1:0]      tower_out_o,
  output logic                    hits_dropped_o,
  output logic                    last_cluster_o
);

  localparam int unsigned AW = $clog2(MAX_HITS);
  localparam int unsigned CW = $clog2(MAX_HITS + 1);
  localparam int unsigned SW = STRIP_BITS;
  localparam logic [CW-1:0] FULL = CW'(MAX_HITS);

  state_e state_q, state_d;

  logic [CFG_W-1:0] cfg_q;
  logic [CW-1:0]    count_q, count_d;
  logic             ovf_q, ovf_d;
  logic [ID_W-1:0]  ctr_q, ctr_d;
  logic [AW-1:0]    idx_q, idx_d;
  logic [SW-1:0]    s_q, s_d;
  logic [SW-1:0]    lo_q, lo_d, hi_q, hi_d;
  logic             view_q, last_q;
  logic [LAYER_W-1:0] layer_q;
  logic [TOWER_W-1:0] tower_q;
  logic [TOT_W-1:0]   tot_q;

  logic                    out_valid_q;
  logic [ID_W-1:0]         id_q;
  logic                    oview_q, drop_q, olast_q;
  logic [LAYER_W-1:0]      plane_q;
  logic [PORT_STRIP_W-1:0] olo_q, ohi_q;
  logic [TOT_W-1:0]        otot_q;
  logic [TOWER_W-1:0]      otower_q;

  // RAM and compare unit hookup
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [SW-1:0] ram_wdata, ram_rdata;
  logic [SW-1:0] cmp_b;
  logic          cmp_inc, cmp_gt;

  logic             accept;
  logic             slot_free;
  logic             emit, emit_last;
  logic [SW-1:0]    emit_lo, emit_hi;
  logic [SW-1:0]    strip_kept;
  logic [SW+PORT_STRIP_W-1:0] strip_ext, lo_ext, hi_ext;

  assign strip_ext  = {{SW{1'b0}}, strip_i};
  assign strip_kept = strip_ext[SW-1:0];

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i & in_ready_o;
  assign slot_free  = ~out_valid_q | out_ready_i;

  sthc_ram #(
    .Width(SW),
    .Depth(MAX_HITS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  sthc_cmp #(
    .Width(SW)
  ) u_cmp (
    .a_i  (ram_rdata),
    .b_i  (cmp_b),
    .inc_i(cmp_inc),
    .gt_o (cmp_gt)
  );

  // scan compares against hi + 1, insertion against the new strip
  assign cmp_inc = (state_q == ST_SCAN);
  assign cmp_b   = (state_q == ST_SCAN) ? hi_q : s_q;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    ovf_d     = ovf_q;
    ctr_d     = ctr_q;
    idx_d     = idx_q;
    s_d       = s_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = s_q;
    ram_raddr = idx_q;
    emit      = 1'b0;
    emit_last = 1'b0;
    emit_lo   = lo_q;
    emit_hi   = hi_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          s_d = strip_kept;
          if (new_event_i) begin
            ctr_d = '0;
          end
          if (count_q >= FULL) begin
            ovf_d   = 1'b1;
            state_d = last_hit_i ? ST_SCAN0 : ST_IDLE;
          end else if (count_q == '0) begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = strip_kept;
            count_d   = count_q + CW'(1);
            state_d   = last_hit_i ? ST_SCAN0 : ST_IDLE;
          end else begin
            idx_d     = AW'(count_q);
            ram_raddr = AW'(count_q - CW'(1));
            state_d   = ST_INSERT;
          end
        end
      end

      ST_INSERT: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        if (cmp_gt) begin
          // shift the larger entry up one place
          ram_wdata = ram_rdata;
          idx_d     = idx_q - AW'(1);
          ram_raddr = idx_q - AW'(2);
          if (idx_q == AW'(1)) begin
            state_d = ST_PLACE;
          end
        end else begin
          ram_wdata = s_q;
          count_d   = count_q + CW'(1);
          state_d   = last_q ? ST_SCAN0 : ST_IDLE;
        end
      end

      ST_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = s_q;
        count_d   = count_q + CW'(1);
        state_d   = last_q ? ST_SCAN0 : ST_IDLE;
      end

      ST_SCAN0: begin
        ram_raddr = '0;
        state_d   = ST_LOAD;
      end

      ST_LOAD: begin
        lo_d = ram_rdata;
        hi_d = ram_rdata;
        if (count_q == CW'(1)) begin
          state_d = ST_FINAL;
        end else begin
          idx_d     = AW'(1);
          ram_raddr = AW'(1);
          state_d   = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // hold the read address while a new cluster waits for the busy cluster register
        if (!(cmp_gt && !slot_free)) begin
          if (cmp_gt) begin
            emit = 1'b1;
            lo_d = ram_rdata;
          end
          hi_d = ram_rdata;
          if (CW'(idx_q) + CW'(1) == count_q) begin
            state_d = ST_FINAL;
          end else begin
            idx_d     = idx_q + AW'(1);
            ram_raddr = idx_q + AW'(1);
          end
        end
      end

      ST_FINAL: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_last = 1'b1;
          count_d   = '0;
          ovf_d     = 1'b0;
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (emit && ctr_q != ID_MAX) begin
      ctr_d = ctr_q + ID_W'(1);
    end
  end

  assign lo_ext = {{PORT_STRIP_W{1'b0}}, emit_lo};
  assign hi_ext = {{PORT_STRIP_W{1'b0}}, emit_hi};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cfg_q       <= LAYER_COUNT_RESET;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      ctr_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      ctr_q       <= ctr_d;
      idx_q       <= idx_d;
      out_valid_q <= emit | (out_valid_q & ~out_ready_i);
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s_q  <= s_d;
    lo_q <= lo_d;
    hi_q <= hi_d;
    if (accept) begin
      view_q  <= view_select_i;
      layer_q <= layer_number_i;
      tower_q <= tower_number_i;
      tot_q   <= charge_tot_i;
      last_q  <= last_hit_i;
    end
    if (emit) begin
      id_q     <= ctr_q;
      oview_q  <= view_q;
      plane_q  <= cfg_q[LAYER_W-1:0] - layer_q - LAYER_W'(1);
      olo_q    <= lo_ext[PORT_STRIP_W-1:0];
      ohi_q    <= hi_ext[PORT_STRIP_W-1:0];
      otot_q   <= tot_q;
      otower_q <= tower_q;
      drop_q   <= ovf_q;
      olast_q  <= emit_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign cluster_id_o   = id_q;
  assign view_out_o     = oview_q;
  assign plane_number_o = plane_q;
  assign strip_low_o    = olo_q;
  assign strip_high_o   = ohi_q;
  assign tot_out_o      = otot_q;
  assign tower_out_o    = otower_q;
  assign hits_dropped_o = drop_q;
  assign last_cluster_o = olast_q;

endmodule

// File: rtl/sthc_checker.sv
// ----------------------------------------------------------------------------
// Strip hit clusterer checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module sthc_checker
  import sthc_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_o,
  input logic                    last_hit_i,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input logic [ID_W-1:0]         cluster_id_o,
  input logic [PORT_STRIP_W-1:0] strip_low_o,
  input logic [PORT_STRIP_W-1:0] strip_high_o
);

  // a pending cluster transaction is held until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("cluster dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(cluster_id_o))
    else $error("cluster id changed while stalled");

  // the final hit of a layer starts clustering, so input must close
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && last_hit_i |=> !in_ready_o)
    else $error("input still open after last hit");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> strip_low_o <= strip_high_o)
    else $error("cluster low strip above high strip");

endmodule

bind strip_hit_clusterer_unit sthc_checker u_sthc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .last_hit_i  (last_hit_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .cluster_id_o(cluster_id_o),
  .strip_low_o (strip_low_o),
  .strip_high_o(strip_high_o)
);
